// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// antecedent now implies consequent at the next clock edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/stok_pkg.sv =====
package stok_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int KEYWORD_CHARS_DEF = 12;
	localparam int RQ_DEPTH = 8;
	localparam int N_KW = 25;
	localparam int KW_MAX = 11;

	typedef enum logic [11:0] {
		M_IDLE    = 12'b0000_0000_0001,
		M_PAIR    = 12'b0000_0000_0010,
		M_DOT1    = 12'b0000_0000_0100,
		M_DOT2    = 12'b0000_0000_1000,
		M_BLANK   = 12'b0000_0001_0000,
		M_COMMENT = 12'b0000_0010_0000,
		M_NAME    = 12'b0000_0100_0000,
		M_INT     = 12'b0000_1000_0000,
		M_FRAC    = 12'b0001_0000_0000,
		M_E       = 12'b0010_0000_0000,
		M_ESIGN   = 12'b0100_0000_0000,
		M_EXP     = 12'b1000_0000_0000
	} mode_t;

	localparam logic [5:0] K_LPAREN = 6'd0;
	localparam logic [5:0] K_RPAREN = 6'd1;
	localparam logic [5:0] K_LBRACE = 6'd2;
	localparam logic [5:0] K_RBRACE = 6'd3;
	localparam logic [5:0] K_LBRACK = 6'd4;
	localparam logic [5:0] K_RBRACK = 6'd5;
	localparam logic [5:0] K_ASSIGN = 6'd6;
	localparam logic [5:0] K_LT = 6'd8;
	localparam logic [5:0] K_GT = 6'd10;
	localparam logic [5:0] K_AT = 6'd12;
	localparam logic [5:0] K_PERCENT = 6'd13;
	localparam logic [5:0] K_QUERY = 6'd14;
	localparam logic [5:0] K_BANG = 6'd15;
	localparam logic [5:0] K_COLON = 6'd17;
	localparam logic [5:0] K_DOT = 6'd19;
	localparam logic [5:0] K_DOTDOT = 6'd20;
	localparam logic [5:0] K_DOTDOTDOT = 6'd21;
	localparam logic [5:0] K_COMMA = 6'd22;
	localparam logic [5:0] K_PLUS = 6'd23;
	localparam logic [5:0] K_MINUS = 6'd24;
	localparam logic [5:0] K_STAR = 6'd25;
	localparam logic [5:0] K_SLASH = 6'd26;
	localparam logic [5:0] K_CARET = 6'd27;
	localparam logic [5:0] K_BSLASH = 6'd28;
	localparam logic [5:0] K_NEWLINE = 6'd29;
	localparam logic [5:0] K_SPACE = 6'd30;
	localparam logic [5:0] K_TAB = 6'd31;
	localparam logic [5:0] K_UNKNOWN = 6'd32;
	localparam logic [5:0] K_EOF = 6'd33;
	localparam logic [5:0] K_IDENT = 6'd34;
	localparam logic [5:0] K_NUMBER = 6'd35;
	localparam logic [5:0] K_KEYWORD0 = 6'd36;

	// keyword text, right-justified: char j of a word of length L is byte L-1-j
	localparam logic [8*KW_MAX-1:0] KW_TEXT [N_KW] = '{
		"and", "case", "class", "constructor", "continue", "else", "end",
		"extend", "extern", "false", "function", "get", "if", "intern",
		"namespace", "not", "null", "or", "property", "return", "set", "super",
		"true", "when", "while"
	};
	localparam logic [3:0] KW_LEN [N_KW] = '{
		4'd3, 4'd4, 4'd5, 4'd11, 4'd8, 4'd4, 4'd3, 4'd6, 4'd6, 4'd5, 4'd8, 4'd3,
		4'd2, 4'd6, 4'd9, 4'd3, 4'd4, 4'd2, 4'd8, 4'd6, 4'd3, 4'd5, 4'd4, 4'd4, 4'd5
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        experr;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic v;
		tok_t t;
	} slot_t;

	localparam slot_t SLOT_NONE = '0;

	function automatic slot_t mk_slot(input logic [5:0] kind, input logic [15:0] start,
			input logic [15:0] len, input logic experr, input logic last);
		slot_t s;
		s.v = 1'b1;
		s.t.kind = kind;
		s.t.start = start;
		s.t.len = len;
		s.t.experr = experr;
		s.t.last = last;
		return s;
	endfunction

	function automatic logic is_alnum_(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
			(b >= "0" && b <= "9") || b == "_";
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] first, input logic doubled);
		logic [5:0] k;
		case (first)
			"=": k = K_ASSIGN;
			"<": k = K_LT;
			">": k = K_GT;
			"!": k = K_BANG;
			":": k = K_COLON;
			default: k = K_UNKNOWN;
		endcase
		if (k != K_UNKNOWN && doubled)
			k = k + 6'd1;
		return k;
	endfunction

	// token left behind by a held mode when the next byte does not extend it
	function automatic slot_t flush_slot(input mode_t m, input logic [7:0] held,
			input logic [15:0] start, input logic [15:0] len, input logic [5:0] nk);
		slot_t s;
		case (m)
			M_PAIR: s = mk_slot(pair_kind(held, 1'b0), start, len, 1'b0, 1'b0);
			M_DOT1: s = mk_slot(K_DOT, start, len, 1'b0, 1'b0);
			M_DOT2: s = mk_slot(K_DOTDOT, start, len, 1'b0, 1'b0);
			M_BLANK: s = mk_slot((held == " ") ? K_SPACE : K_TAB, start, len, 1'b0, 1'b0);
			M_NAME: s = mk_slot(nk, start, len, 1'b0, 1'b0);
			M_INT, M_FRAC, M_EXP: s = mk_slot(K_NUMBER, start, len, 1'b0, 1'b0);
			M_E, M_ESIGN: s = mk_slot(K_NUMBER, start, len, 1'b1, 1'b0);
			default: s = SLOT_NONE;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/stok_lex.sv =====
module stok_lex #(
	parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF,
	parameter int KEYWORD_CHARS = stok_pkg::KEYWORD_CHARS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                ch,
	input  logic                      eos,
	output stok_pkg::slot_t [2:0]     slots,
	output logic                      idle
);

	localparam int PIW = $clog2(KEYWORD_CHARS);

	stok_pkg::mode_t               mode_q, mode_a, mode_e, mode_n;
	logic [POSITION_BITS-1:0]      pos_q, pos_n, start_q, start_a, start_n, p_inc;
	logic [15:0]                   run_q, run_a, run_e, run_n, grown;
	logic [7:0]                    held_q, held_a, held_n;
	logic                          anl_q, anl_n, taken;
	logic [KEYWORD_CHARS-1:0][7:0] prefix_q, pfx_n;
	logic [5:0]                    nk_cur, nk_next;
	stok_pkg::slot_t               xs, bs, s0, s1, s2;

	function automatic logic [15:0] lo16(input logic [POSITION_BITS-1:0] p);
		logic [POSITION_BITS+15:0] e;
		e = {16'd0, p};
		return e[15:0];
	endfunction

	// parallel compare of the stored name against every keyword
	function automatic logic [5:0] name_kind(input logic [KEYWORD_CHARS-1:0][7:0] pfx,
			input logic [15:0] len);
		logic [5:0] k;
		logic       hit;
		k = stok_pkg::K_IDENT;
		for (int i = 0; i < stok_pkg::N_KW; i++) begin
			hit = (len == {12'd0, stok_pkg::KW_LEN[i]});
			for (int j = 0; j < stok_pkg::KW_MAX; j++) begin
				if (j < int'(stok_pkg::KW_LEN[i]) &&
						pfx[j] != stok_pkg::KW_TEXT[i][8*(int'(stok_pkg::KW_LEN[i])-1-j) +: 8])
					hit = 1'b0;
			end
			if (hit)
				k = stok_pkg::K_KEYWORD0 + 6'(i);
		end
		return k;
	endfunction

	assign grown = (run_q == 16'hFFFF) ? run_q : run_q + 16'd1;
	assign p_inc = pos_q + POSITION_BITS'(1);
	assign nk_cur = name_kind(prefix_q, run_q);
	assign nk_next = name_kind(pfx_n, run_a);
	assign idle = (mode_q == stok_pkg::M_IDLE);

	always_comb begin
		taken = 1'b0;
		mode_e = stok_pkg::M_IDLE;
		run_e = grown;
		xs = stok_pkg::SLOT_NONE;
		pfx_n = prefix_q;
		// try to extend the held token
		case (mode_q)
			stok_pkg::M_PAIR: begin
				if (ch == (((held_q == "=") || (held_q == ":")) ? held_q : 8'("="))) begin
					taken = 1'b1;
					xs = stok_pkg::mk_slot(stok_pkg::pair_kind(held_q, 1'b1), lo16(start_q),
						grown, 1'b0, 1'b0);
				end
			end
			stok_pkg::M_DOT1: begin
				taken = (ch == ".");
				mode_e = stok_pkg::M_DOT2;
			end
			stok_pkg::M_DOT2: begin
				if (ch == ".") begin
					taken = 1'b1;
					xs = stok_pkg::mk_slot(stok_pkg::K_DOTDOTDOT, lo16(start_q), grown,
						1'b0, 1'b0);
				end
			end
			stok_pkg::M_BLANK: begin
				taken = (ch == held_q);
				mode_e = stok_pkg::M_BLANK;
			end
			stok_pkg::M_COMMENT: begin
				taken = (ch != "\n");
				mode_e = stok_pkg::M_COMMENT;
				run_e = run_q;
			end
			stok_pkg::M_NAME: begin
				taken = stok_pkg::is_alnum_(ch);
				mode_e = stok_pkg::M_NAME;
				if (taken && run_q < 16'(KEYWORD_CHARS))
					pfx_n[run_q[PIW-1:0]] = ch;
			end
			stok_pkg::M_INT: begin
				if (ch >= "0" && ch <= "9") begin
					taken = 1'b1; mode_e = stok_pkg::M_INT;
				end else if (ch == ".") begin
					taken = 1'b1; mode_e = stok_pkg::M_FRAC;
				end else if (ch == "e" || ch == "E") begin
					taken = 1'b1; mode_e = stok_pkg::M_E;
				end
			end
			stok_pkg::M_FRAC: begin
				if (ch >= "0" && ch <= "9") begin
					taken = 1'b1; mode_e = stok_pkg::M_FRAC;
				end else if (ch == "e" || ch == "E") begin
					taken = 1'b1; mode_e = stok_pkg::M_E;
				end
			end
			stok_pkg::M_E: begin
				if (ch == "-") begin
					taken = 1'b1; mode_e = stok_pkg::M_ESIGN;
				end else if (ch >= "0" && ch <= "9") begin
					taken = 1'b1; mode_e = stok_pkg::M_EXP;
				end
			end
			stok_pkg::M_ESIGN, stok_pkg::M_EXP: begin
				taken = (ch >= "0" && ch <= "9");
				mode_e = stok_pkg::M_EXP;
			end
			default: taken = 1'b0;
		endcase

		bs = stok_pkg::SLOT_NONE;
		if (taken) begin
			s0 = xs;
			mode_a = mode_e;
			run_a = run_e;
			start_a = start_q;
			held_a = held_q;
		end else begin
			s0 = stok_pkg::flush_slot(mode_q, held_q, lo16(start_q), run_q, nk_cur);
			mode_a = stok_pkg::M_IDLE;
			run_a = 16'd1;
			start_a = pos_q;
			held_a = held_q;
			// first byte of a new token
			case (ch) inside
				"(": bs = stok_pkg::mk_slot(stok_pkg::K_LPAREN, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				")": bs = stok_pkg::mk_slot(stok_pkg::K_RPAREN, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"{": bs = stok_pkg::mk_slot(stok_pkg::K_LBRACE, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"}": bs = stok_pkg::mk_slot(stok_pkg::K_RBRACE, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"[": bs = stok_pkg::mk_slot(stok_pkg::K_LBRACK, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"]": bs = stok_pkg::mk_slot(stok_pkg::K_RBRACK, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"@": bs = stok_pkg::mk_slot(stok_pkg::K_AT, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"%": bs = stok_pkg::mk_slot(stok_pkg::K_PERCENT, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"?": bs = stok_pkg::mk_slot(stok_pkg::K_QUERY, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				",": bs = stok_pkg::mk_slot(stok_pkg::K_COMMA, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"+": bs = stok_pkg::mk_slot(stok_pkg::K_PLUS, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"-": bs = stok_pkg::mk_slot(stok_pkg::K_MINUS, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"*": bs = stok_pkg::mk_slot(stok_pkg::K_STAR, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"/": bs = stok_pkg::mk_slot(stok_pkg::K_SLASH, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"^": bs = stok_pkg::mk_slot(stok_pkg::K_CARET, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"\\": bs = stok_pkg::mk_slot(stok_pkg::K_BSLASH, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"\n": bs = stok_pkg::mk_slot(stok_pkg::K_NEWLINE, lo16(pos_q), 16'd1, 1'b0, 1'b0);
				"=", "<", ">", "!", ":": begin
					held_a = ch;
					mode_a = stok_pkg::M_PAIR;
				end
				".": mode_a = stok_pkg::M_DOT1;
				"'", "\"": mode_a = stok_pkg::M_IDLE;
				" ", "\t": begin
					if (anl_q) begin
						held_a = ch;
						mode_a = stok_pkg::M_BLANK;
					end
				end
				"#": mode_a = stok_pkg::M_COMMENT;
				["0":"9"]: mode_a = stok_pkg::M_INT;
				["a":"z"], ["A":"Z"], "_": begin
					pfx_n[0] = ch;
					mode_a = stok_pkg::M_NAME;
				end
				default: bs = stok_pkg::mk_slot(stok_pkg::K_UNKNOWN, lo16(pos_q), 16'd1,
					1'b0, 1'b0);
			endcase
		end

		// a begin that emits leaves no held token, so slot 1 carries one or the other
		if (bs.v)
			s1 = bs;
		else if (eos)
			s1 = stok_pkg::flush_slot(mode_a, held_a, lo16(start_a), run_a, nk_next);
		else
			s1 = stok_pkg::SLOT_NONE;
		s2 = eos ? stok_pkg::mk_slot(stok_pkg::K_EOF, lo16(p_inc), 16'd0, 1'b0, 1'b1)
			: stok_pkg::SLOT_NONE;

		if (eos) begin
			mode_n = stok_pkg::M_IDLE;
			pos_n = '0;
			start_n = '0;
			run_n = 16'd0;
			held_n = 8'd0;
			anl_n = 1'b1;
		end else begin
			mode_n = mode_a;
			pos_n = p_inc;
			start_n = start_a;
			run_n = run_a;
			held_n = held_a;
			anl_n = (ch == "\n");
		end
	end

	assign slots = {s2, s1, s0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stok_pkg::M_IDLE;
			pos_q <= '0;
			start_q <= '0;
			run_q <= 16'd0;
			held_q <= 8'd0;
			anl_q <= 1'b1;
		end else if (step) begin
			mode_q <= mode_n;
			pos_q <= pos_n;
			start_q <= start_n;
			run_q <= run_n;
			held_q <= held_n;
			anl_q <= anl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			prefix_q <= pfx_n;
	end

endmodule

// ===== rtl/stok_rq.sv =====
module stok_rq (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  stok_pkg::slot_t [2:0]                  push,
	input  logic                                   pop,
	output stok_pkg::tok_t                         head,
	output logic [$clog2(stok_pkg::RQ_DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(stok_pkg::RQ_DEPTH);
	localparam int CW = $clog2(stok_pkg::RQ_DEPTH+1);

	stok_pkg::tok_t mem_q [stok_pkg::RQ_DEPTH];
	logic [AW-1:0]  wp_q, rp_q, a1, a2;
	logic [CW-1:0]  count_q, n_push;

	// pack the valid slots in order behind the write pointer
	assign a1 = wp_q + AW'(push[0].v);
	assign a2 = a1 + AW'(push[1].v);
	assign n_push = CW'(push[0].v) + CW'(push[1].v) + CW'(push[2].v);
	assign head = mem_q[rp_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + AW'(n_push);
			if (pop)
				rp_q <= rp_q + AW'(1);
			count_q <= count_q + n_push - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push[0].v)
			mem_q[wp_q] <= push[0].t;
		if (push[1].v)
			mem_q[a1] <= push[1].t;
		if (push[2].v)
			mem_q[a2] <= push[2].t;
	end

endmodule

// ===== rtl/source_tokenizer.sv =====
// Source tokenizer: byte stream in, token stream out.
// Input channel (s_axis): one source byte per beat in tdata[7:0]; tlast marks
// the last byte of a source. Output channel (m_axis): one token per beat,
// start offset and length in tdata, kind and exponent error flag in tuser,
// tlast set on the end-of-source token that closes every source.
// Each byte is registered, then lexed against the held-token
// state; the 0 to 3 tokens it produces go into an 8-entry result queue.
// A token that a byte completes is offered once the lexer has written it into
// the result queue. Tokens held for lookahead wait for the byte that ends them.
// Throughput: one byte per cycle while the queue has room for three tokens;
// the output drains one token per cycle, so a stalled or slow receiver fills
// the queue and then tready drops until space returns. Nothing is lost.
// Reset clears the lexer state (line start, offset zero) and empties the
// queue; after each end-of-source token the lexer returns to the same state.
`include "assert_macros.svh"

module source_tokenizer #(
	parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF,
	parameter int KEYWORD_CHARS = stok_pkg::KEYWORD_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  logic        s_axis_tlast,  // end_of_source
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [15:0] token_start, [31:16] token_length
	output logic [6:0]  m_axis_tuser,  // [5:0] token_kind, [6] exponent_error
	output logic        m_axis_tlast   // last_token
);

	localparam int CW = $clog2(stok_pkg::RQ_DEPTH+1);

	logic                  valid_s1, eos_s1, proc, lex_idle;
	logic [7:0]            ch_s1;
	stok_pkg::slot_t [2:0] slots;
	stok_pkg::tok_t        head;
	logic [CW-1:0]         count;

	// lex a byte only when the queue can take the worst case of three tokens
	assign proc = valid_s1 && (count <= CW'(stok_pkg::RQ_DEPTH - 3));
	assign s_axis_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1 <= s_axis_tdata;
			eos_s1 <= s_axis_tlast;
		end
	end

	stok_lex #(
		.POSITION_BITS(POSITION_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_lex (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (proc),
		.ch    (ch_s1),
		.eos   (eos_s1),
		.slots (slots),
		.idle  (lex_idle)
	);

	stok_rq u_rq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (proc ? slots : {3{stok_pkg::SLOT_NONE}}),
		.pop   (m_axis_tvalid && m_axis_tready),
		.head  (head),
		.count (count)
	);

	assign m_axis_tvalid = (count != '0);
	assign m_axis_tdata = {head.len, head.start};
	assign m_axis_tuser = {head.experr, head.kind};
	assign m_axis_tlast = head.last;

	`ASSERT_HOLDS(a_rq_bound, clk, arst_n, count <= CW'(stok_pkg::RQ_DEPTH))
	`ASSERT_NEXT(a_eos_output, clk, arst_n, proc && eos_s1, m_axis_tvalid)
	`ASSERT_NEXT(a_eos_idle, clk, arst_n, proc && eos_s1, lex_idle)

endmodule
